// ----- sv/rlt_pkg.sv -----
// Package with the types, codes and sizes shared by the recursive lock table.
`default_nettype none

package rlt_pkg;

    localparam int SLOT_BITS  = 8;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int KEY_BITS   = 26;
    localparam int OWNER_BITS = 32;
    localparam int DEPTH_BITS = 16;
    localparam int ENTRY_BITS = KEY_BITS + OWNER_BITS + DEPTH_BITS;

    localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;

    // Byte address of the offset register.
    localparam logic [2:0] REG_ADDR_OFFSET = 3'd0;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ENTER = 2'd1,
        OP_LEAVE = 2'd2,
        OP_SPARE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_BUSY     = 3'd1,
        ST_FULL     = 3'd2,
        ST_UNBAL    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_SAT      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_HASH  = 2'd1,
        S_PROBE = 2'd2
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [OWNER_BITS-1:0] owner;
        logic [DEPTH_BITS-1:0] depth;
    } t_entry;

endpackage

`default_nettype wire

// ----- sv/recursive_lock_table.sv -----
// Top level of the recursive lock table: request decode, probe sequencer and slot memory.
`default_nettype none

// Each request is accepted, hashed and then probed, starting at the slot at its hash and
// moving on one slot at a time along the linear probe until its key or an empty slot is
// found or every slot has been read. The probe loop reads one slot of the single slot memory
// per cycle. Requests with a null address or an unused opcode are resolved in the hash step
// without a probe. The input is ready again in the cycle after the request is resolved, even
// while its result still waits in the output register. The table starts empty after reset:
// per-slot valid bits make a never-written slot read as empty, so no clearing pass is needed.
module recursive_lock_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] lock_address, [63:32] thread_id
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata    // [2:0] status, [10:3] slot_index,
                                             // [26:11] held_depth, [31:27] zero
);

    localparam int SB = rlt_pkg::SLOT_BITS;
    localparam int KB = rlt_pkg::KEY_BITS;
    localparam int DB = rlt_pkg::DEPTH_BITS;
    localparam int OB = rlt_pkg::OWNER_BITS;

    // Configuration register.
    logic [31:0] r_addr_offset;
    logic        w_cfg_write;
    logic        w_cfg_sel;

    assign pready      = 1'b1;
    assign w_cfg_sel   = (paddr[2] == rlt_pkg::REG_ADDR_OFFSET[2]);
    assign w_cfg_write = psel && penable && pwrite && w_cfg_sel;
    assign prdata      = (psel && !pwrite && w_cfg_sel) ? r_addr_offset : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_offset <= 32'd0;
        end else if (w_cfg_write) begin
            r_addr_offset <= pwdata;
        end
    end

    // Request registers.
    rlt_pkg::t_state    r_state, n_state;
    logic [1:0]         r_op;
    logic [OB-1:0]      r_tid;
    logic [KB-1:0]      r_key;
    logic               r_null;
    logic [SB-1:0]      r_idx, n_idx;
    logic [SB-1:0]      r_count, n_count;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_data, n_out_data;

    // Slot memory and its valid bits.
    rlt_pkg::t_entry    r_mem [rlt_pkg::SLOT_COUNT];
    logic [rlt_pkg::SLOT_COUNT-1:0] r_valid;
    rlt_pkg::t_entry    r_rd_data;
    logic               r_rd_valid;

    logic               w_accept;
    logic [KB-1:0]      w_diff;
    logic [KB-1:0]      w_key;
    logic [SB-1:0]      w_prod;
    logic               w_out_free;
    logic               w_load;
    logic               w_we;
    logic               w_wr;
    rlt_pkg::t_entry    w_wdata;
    rlt_pkg::t_entry    w_slot;
    logic               w_hit;
    logic               w_empty;
    logic [DB-1:0]      w_depth_dec;
    logic [DB-1:0]      w_depth_inc;
    rlt_pkg::t_status   w_status;
    logic [SB-1:0]      w_res_idx;
    logic [DB-1:0]      w_res_depth;

    assign s_axis_tready = (r_state == rlt_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Key: address less the offset, masked, with zero folded onto one.
    assign w_diff = s_axis_tdata[KB-1:0] - r_addr_offset[KB-1:0];
    assign w_key  = (w_diff == '0) ? KB'(1) : w_diff;

    // Only the low slot bits of the hash product matter.
    assign w_prod = r_key[SB-1:0] * rlt_pkg::HASH_MUL[SB-1:0];

    assign w_out_free = !r_out_valid || m_axis_tready;

    // A slot that was never written reads as empty.
    assign w_slot      = r_rd_valid ? r_rd_data : '0;
    assign w_empty     = !r_rd_valid;
    assign w_hit       = r_rd_valid && (r_rd_data.key == r_key);
    assign w_depth_dec = w_slot.depth - DB'(1);
    assign w_depth_inc = w_slot.depth + DB'(1);

    // Outcome of a resolved probe and the slot write-back it causes.
    always_comb begin
        w_we        = 1'b0;
        w_wdata     = w_slot;
        w_status    = rlt_pkg::ST_DONE;
        w_res_idx   = r_idx;
        w_res_depth = w_slot.depth;
        if (!w_hit) begin
            // A newly created slot starts free.
            w_wdata.key   = r_key;
            w_wdata.owner = '0;
            w_wdata.depth = '0;
        end
        case (r_op)
            rlt_pkg::OP_LEAVE: begin
                if (!w_hit) begin
                    w_status    = rlt_pkg::ST_NOTFOUND;
                    w_res_idx   = '0;
                    w_res_depth = '0;
                end else if (r_tid == '0 || w_slot.owner != r_tid || w_slot.depth == '0) begin
                    w_status = rlt_pkg::ST_UNBAL;
                end else begin
                    w_we          = 1'b1;
                    w_wdata.depth = w_depth_dec;
                    w_wdata.owner = (w_depth_dec == '0) ? '0 : w_slot.owner;
                    w_res_depth   = w_depth_dec;
                end
            end
            rlt_pkg::OP_INIT, rlt_pkg::OP_ENTER: begin
                if (!w_hit && !w_empty) begin
                    w_status    = rlt_pkg::ST_FULL;
                    w_res_idx   = '0;
                    w_res_depth = '0;
                end else begin
                    w_we = !w_hit;
                    if (r_op == rlt_pkg::OP_INIT) begin
                        w_status    = rlt_pkg::ST_DONE;
                        w_res_depth = w_wdata.depth;
                    end else if (r_tid == '0) begin
                        w_status    = rlt_pkg::ST_BUSY;
                        w_res_depth = w_wdata.depth;
                    end else if (w_wdata.depth == '0) begin
                        w_we          = 1'b1;
                        w_wdata.owner = r_tid;
                        w_wdata.depth = DB'(1);
                        w_res_depth   = DB'(1);
                    end else if (w_slot.owner != r_tid) begin
                        w_status = rlt_pkg::ST_BUSY;
                    end else if (w_slot.depth == '1) begin
                        w_status = rlt_pkg::ST_SAT;
                    end else begin
                        w_we          = 1'b1;
                        w_wdata.depth = w_depth_inc;
                        w_res_depth   = w_depth_inc;
                    end
                end
            end
            default: begin
                w_status    = rlt_pkg::ST_DONE;
                w_res_idx   = '0;
                w_res_depth = '0;
            end
        endcase
    end

    // Sequencer: next state, probe address and result loading.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_load      = 1'b0;
        case (r_state)
            rlt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = rlt_pkg::S_HASH;
                end
            end
            rlt_pkg::S_HASH: begin
                if (r_op == rlt_pkg::OP_SPARE || r_null) begin
                    if (w_out_free) begin
                        w_load      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        n_out_data[2:0] = (r_op == rlt_pkg::OP_SPARE) ? rlt_pkg::ST_DONE
                                                                      : rlt_pkg::ST_NOTFOUND;
                        n_state = rlt_pkg::S_IDLE;
                    end
                end else begin
                    n_idx   = w_prod;
                    n_count = '0;
                    n_state = rlt_pkg::S_PROBE;
                end
            end
            rlt_pkg::S_PROBE: begin
                if (w_hit || w_empty || r_count == SB'(rlt_pkg::SLOT_COUNT - 1)) begin
                    // Hold the probe address while the result cannot be stored.
                    if (w_out_free) begin
                        w_load      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_data  = {5'd0, w_res_depth, w_res_idx, w_status};
                        n_state     = rlt_pkg::S_IDLE;
                    end
                end else begin
                    n_idx   = r_idx + SB'(1);
                    n_count = r_count + SB'(1);
                end
            end
            default: begin
                n_state = rlt_pkg::S_IDLE;
            end
        endcase
    end

    // Only a resolved probe writes its slot back.
    assign w_wr = w_we && w_load && (r_state == rlt_pkg::S_PROBE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlt_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_count    <= n_count;
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_tid  <= s_axis_tdata[63:32];
            r_key  <= w_key;
            r_null <= (s_axis_tdata[31:0] == 32'd0);
        end
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_idx] <= w_wdata;
        end
        r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (w_wr) begin
                r_valid[r_idx] <= 1'b1;
            end
            r_rd_valid <= r_valid[n_idx];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An accepted request always moves on to hashing.
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == rlt_pkg::S_HASH)
        else $error("accepted request did not enter the hash step");

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || m_axis_tready))
        else $error("result loaded over a pending result");

    // A slot that was written reads as occupied from then on.
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> r_valid[$past(r_idx)])
        else $error("written slot not marked valid");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the recursive lock table: stream stimulus, slot-table prediction and checking.
`default_nettype none

module testbench;

    localparam int          SB              = rlt_pkg::SLOT_BITS;
    localparam int          KB              = rlt_pkg::KEY_BITS;
    localparam int          DB              = rlt_pkg::DEPTH_BITS;
    localparam int          OB              = rlt_pkg::OWNER_BITS;
    localparam int          SLOTS           = rlt_pkg::SLOT_COUNT;
    localparam logic [31:0] KEY_MASK        = (32'd1 << KB) - 32'd1;
    localparam int          HOLD_LEN        = 400;
    localparam int          DRAIN_CYCLES    = 300;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] tid;
    } t_lock_request;

    typedef struct packed {
        logic [2:0]    status;
        logic [SB-1:0] slot;
        logic [DB-1:0] depth;
    } t_lock_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // [31:0] lock_address, [63:32] thread_id
    logic [1:0]  s_axis_tuser = '0;    // [1:0] opcode
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;         // [2:0] status, [10:3] slot_index,
                                       // [26:11] held_depth, [31:27] zero

    // Shadow copy of the slot memory and the offset register.
    logic [KB-1:0] lock_key   [SLOTS];
    logic [OB-1:0] lock_owner [SLOTS];
    logic [DB-1:0] lock_depth [SLOTS];
    logic [31:0]   guest_offset = '0;

    t_lock_request lock_requests[$];
    t_lock_reply   predicted_replies[$];
    t_lock_request offered_request;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    logic hold_trigger = 1'b0;
    int mismatch_count = 0;

    recursive_lock_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the reply it must produce.
    function automatic t_lock_reply resolve_lock(t_lock_request rq);
        t_lock_reply   r;
        logic [31:0]   key;
        logic [31:0]   h;
        logic [SB-1:0] s;
        logic [SB-1:0] idx;
        bit            found;
        bit            have_empty;
        int            i;
        r = '0;
        r.status = rlt_pkg::ST_DONE;
        if (rq.op == rlt_pkg::OP_SPARE) return r;
        if (rq.addr == 32'd0) begin
            r.status = rlt_pkg::ST_NOTFOUND;
            return r;
        end
        key = (rq.addr - guest_offset) & KEY_MASK;
        if (key == 32'd0) key = 32'd1;
        h = key * rlt_pkg::HASH_MUL;
        found = 1'b0;
        have_empty = 1'b0;
        idx = '0;
        for (i = 0; i < SLOTS && !found && !have_empty; i++) begin
            s = h[SB-1:0] + i[SB-1:0];
            if (lock_key[s] == key[KB-1:0]) begin
                found = 1'b1;
                idx = s;
            end else if (lock_key[s] == '0) begin
                have_empty = 1'b1;
                idx = s;
            end
        end
        if (rq.op == rlt_pkg::OP_LEAVE) begin
            if (!found) begin
                r.status = rlt_pkg::ST_NOTFOUND;
                return r;
            end
            r.slot = idx;
            if (rq.tid == 32'd0 || lock_owner[idx] != rq.tid || lock_depth[idx] == '0) begin
                r.status = rlt_pkg::ST_UNBAL;
            end else begin
                lock_depth[idx] = lock_depth[idx] - DB'(1);
                if (lock_depth[idx] == '0) lock_owner[idx] = '0;
            end
            r.depth = lock_depth[idx];
            return r;
        end
        if (!found) begin
            if (!have_empty) begin
                r.status = rlt_pkg::ST_FULL;
                return r;
            end
            lock_key[idx] = key[KB-1:0];
            lock_owner[idx] = '0;
            lock_depth[idx] = '0;
        end
        r.slot = idx;
        if (rq.op == rlt_pkg::OP_ENTER) begin
            if (rq.tid == 32'd0) begin
                r.status = rlt_pkg::ST_BUSY;
            end else if (lock_depth[idx] == '0) begin
                lock_owner[idx] = rq.tid;
                lock_depth[idx] = DB'(1);
            end else if (lock_owner[idx] != rq.tid) begin
                r.status = rlt_pkg::ST_BUSY;
            end else if (lock_depth[idx] == '1) begin
                r.status = rlt_pkg::ST_SAT;
            end else begin
                lock_depth[idx] = lock_depth[idx] + DB'(1);
            end
        end
        r.depth = lock_depth[idx];
        return r;
    endfunction

    // Request driver: predicts each accepted request, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predicted_replies.push_back(resolve_lock(offered_request));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (lock_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_request = lock_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {offered_request.tid, offered_request.addr};
                    s_axis_tuser <= offered_request.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and obeyed by the reply monitor.
    always @(posedge i_clk) begin
        if (hold_trigger)
            hold_cycles <= HOLD_LEN;
        else if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Reply monitor: compares every accepted reply with the oldest prediction.
    always @(posedge i_clk) begin
        t_lock_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (predicted_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: reply with none outstanding, expected none, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = predicted_replies.pop_front();
                if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[10:3] !== want.slot ||
                    m_axis_tdata[26:11] !== want.depth || m_axis_tdata[31:27] !== 5'd0) begin
                    mismatch_count++;
                    $display("%0t: reply mismatch, expected status %0d slot %0d depth %0d,",
                             $time, want.status, want.slot, want.depth,
                             " actual status %0d slot %0d depth %0d pad %h",
                             m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tdata[26:11],
                             m_axis_tdata[31:27]);
                end
            end
        end
        if (hold_cycles != 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic queue_lock(input logic [1:0] op, input logic [31:0] addr,
                              input logic [31:0] tid);
        t_lock_request rq;
        rq.op = op;
        rq.addr = addr;
        rq.tid = tid;
        lock_requests.push_back(rq);
    endtask

    // Writes the offset register, then reads it back.
    task automatic write_offset(input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rlt_pkg::REG_ADDR_OFFSET;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        guest_offset = value;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value || pready !== 1'b1) begin
            mismatch_count++;
            $display("%0t: offset readback mismatch, expected %h, actual %h ready %b",
                     $time, value, prdata, pready);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Returns once every request has been accepted and every reply has arrived.
    task automatic wait_quiet();
        while (lock_requests.size() != 0 || s_axis_tvalid || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly nested enter/leave runs on a few locks and threads, with broken runs and noise.
    task automatic queue_random_locks(input int count);
        logic [31:0] addr_pool [16];
        logic [31:0] tid_pool [4];
        logic [31:0] a;
        logic [31:0] t;
        int queued;
        int nest;
        int leaves;
        int pick;
        int k;
        for (k = 0; k < 16; k++) addr_pool[k] = $urandom;
        for (k = 0; k < 4; k++) begin
            tid_pool[k] = $urandom;
            if (tid_pool[k] == 32'd0) tid_pool[k] = 32'd1;
        end
        queued = 0;
        while (queued < count) begin
            a = addr_pool[$urandom_range(15)];
            t = tid_pool[$urandom_range(3)];
            pick = $urandom_range(99);
            if (pick < 60) begin
                nest = $urandom_range(1, 4);
                leaves = nest;
                k = $urandom_range(99);
                if (k < 8) leaves = nest - 1;
                else if (k < 15) leaves = nest + 1;
                for (k = 0; k < nest; k++) queue_lock(rlt_pkg::OP_ENTER, a, t);
                for (k = 0; k < leaves; k++) queue_lock(rlt_pkg::OP_LEAVE, a, t);
                queued += nest + leaves;
            end else begin
                if (pick < 72) begin
                    queue_lock(rlt_pkg::OP_ENTER, a, t);
                end else if (pick < 82) begin
                    queue_lock(rlt_pkg::OP_LEAVE, a, t);
                end else if (pick < 88) begin
                    queue_lock(rlt_pkg::OP_INIT, a, t);
                end else begin
                    if ($urandom_range(7) == 0) a = 32'd0;
                    else a = $urandom;
                    if ($urandom_range(15) == 0) t = 32'd0;
                    else t = $urandom;
                    queue_lock(2'($urandom_range(3)), a, t);
                end
                queued++;
            end
        end
    endtask

    initial begin
        int k;
        logic [31:0] base;
        for (k = 0; k < SLOTS; k++) begin
            lock_key[k] = '0;
            lock_owner[k] = '0;
            lock_depth[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_offset(32'd0);

        send_idle_pct = 22;
        recv_stall_pct = 84;
        // Directed part at offset zero: null address, absent key, thread zero,
        // busy, unbalanced leave, key folding and the spare opcode.
        queue_lock(rlt_pkg::OP_SPARE, 32'h1234_5678, 32'd5);
        queue_lock(rlt_pkg::OP_INIT, 32'd0, 32'd5);
        queue_lock(rlt_pkg::OP_ENTER, 32'd0, 32'd5);
        queue_lock(rlt_pkg::OP_LEAVE, 32'd0, 32'd5);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_INIT, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_ENTER, 32'h100, 32'd0);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h100, 32'd0);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_ENTER, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_ENTER, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_ENTER, 32'h100, 32'd9);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h100, 32'd9);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h100, 32'd7);
        queue_lock(rlt_pkg::OP_ENTER, 32'h0400_0000, 32'hFFFF_FFFF);
        queue_lock(rlt_pkg::OP_ENTER, 32'd1, 32'hFFFF_FFFF);
        queue_lock(rlt_pkg::OP_ENTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_lock(rlt_pkg::OP_LEAVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_lock(rlt_pkg::OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h0400_0000, 32'hFFFF_FFFF);
        queue_lock(rlt_pkg::OP_LEAVE, 32'd1, 32'hFFFF_FFFF);
        wait_quiet();

        write_offset($urandom);
        queue_random_locks(150);
        wait_quiet();

        send_idle_pct = 84;
        recv_stall_pct = 22;
        write_offset(32'hFFFF_FFFF);
        queue_random_locks(150);
        wait_quiet();

        // Nest one lock deeply, contest it from another thread, then unwind part of it.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_offset($urandom);
        for (k = 0; k < 20; k++) queue_lock(rlt_pkg::OP_ENTER, 32'h00AB_C000, 32'h5A5A_5A5A);
        queue_lock(rlt_pkg::OP_ENTER, 32'h00AB_C000, 32'd3);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h00AB_C000, 32'h5A5A_5A5A);
        queue_lock(rlt_pkg::OP_ENTER, 32'h00AB_C000, 32'h5A5A_5A5A);
        queue_lock(rlt_pkg::OP_LEAVE, 32'h00AB_C000, 32'd3);
        wait_quiet();

        queue_random_locks(150);
        @(posedge i_clk);
        hold_trigger <= 1'b1;
        @(posedge i_clk);
        hold_trigger <= 1'b0;
        @(negedge i_clk);
        wait_quiet();

        // Fill the table with fresh keys until it overflows, then work on a full table.
        write_offset(32'h8000_0000);
        base = $urandom & 32'hFFF0_0000;
        for (k = 0; k < 270; k++) queue_lock(rlt_pkg::OP_INIT, base + 32'(k * 4), 32'd1);
        for (k = 0; k < 20; k++)
            queue_lock(2'($urandom_range(2)), base + 32'($urandom_range(279) * 4),
                       32'($urandom_range(1, 3)));
        queue_lock(rlt_pkg::OP_ENTER, base ^ 32'h0008_0000, 32'd2);
        queue_lock(rlt_pkg::OP_LEAVE, base ^ 32'h0008_0000, 32'd2);
        wait_quiet();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_replies.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/rlt_pkg.sv
sv/recursive_lock_table.sv
tb/testbench.sv
